// ----- src/sdtq_pkg.sv -----
// Shared types, constants and codes for the sorted deadline timer queue.
`timescale 1ns / 1ps

package sdtq_pkg;

    // Default configuration
    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int TAG_BITS_DEF  = 16;

    // Fixed handle space and per-check result limit
    localparam int HANDLE_BITS = 4;
    localparam int NUM_HANDLES = 16;
    localparam int MAX_OUT     = 16;

    localparam logic [31:0] EMPTY_WAIT = 32'd2147483646;
    localparam logic [31:0] WAIT_SAT   = 32'hFFFF_FFFF;

    // Request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CHECK  = 2'd2;
    localparam logic [1:0] REQ_WAIT   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Result of the shared compare/subtract unit
    typedef struct packed {
        logic        a_lt_b;
        logic        a_eq_b;
        logic [31:0] wait_sat;
    } sdtq_cmp_t;

endpackage

// ----- src/sdtq_cmp.sv -----
// Shared compare/subtract unit: orders two times and forms the saturated gap.
`timescale 1ns / 1ps

module sdtq_cmp #(
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0] a_val,
    input  logic [TIME_BITS-1:0] b_val,
    output sdtq_pkg::sdtq_cmp_t  res
);
    import sdtq_pkg::*;

    localparam int XW = TIME_BITS + 32;

    logic [TIME_BITS:0] diff;
    logic [XW-1:0]      diff_ext;

    assign diff     = {1'b0, a_val} - {1'b0, b_val};
    assign diff_ext = XW'(diff[TIME_BITS-1:0]);

    always_comb begin
        res.a_lt_b = diff[TIME_BITS];
        res.a_eq_b = (diff == '0);
        if (res.a_lt_b || res.a_eq_b) begin
            res.wait_sat = '0;
        end else if (diff_ext > XW'(WAIT_SAT)) begin
            res.wait_sat = WAIT_SAT;
        end else begin
            res.wait_sat = diff_ext[31:0];
        end
    end

endmodule

// ----- src/sorted_deadline_timer_queue_unit.sv -----
// Top level of the sorted deadline timer queue: sequencer, entry memory, handle mask.
`timescale 1ns / 1ps

// Keeps up to DEPTH alarms sorted by deadline, earliest first, in a one-port
// entry memory walked by a small sequencer around one shared comparator.
// Input beats (s_*) carry a request: add, remove by handle, check expiries
// against s_now_seconds, or wait query. s_ready is high only while idle;
// one request is taken at a time and all its result beats go out on m_*,
// the final one flagged by m_last. A check gives one beat per fired alarm
// (at most 16), or one empty beat.
// Each memory step is a registered read, then a compare and write. An add
// steps over the entries at or after its insert point; a remove steps over
// all held entries; a check steps from the head while entries are due, then
// moves the rest down; a wait reads the head. A full add, an unknown handle
// and a wait on an empty queue are answered without a memory step.
// Result beats sit in an output register; a stalled receiver holds the
// sequencer at its next emit. Synchronous active-low reset empties the queue
// and frees all handles; the memory itself is not cleared.
module sorted_deadline_timer_queue_unit #(
    parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS  = sdtq_pkg::TAG_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_now_seconds,
    input  logic [31:0] s_deadline,
    input  logic [15:0] s_tag_in,
    input  logic [3:0]  s_handle_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_handle_out,
    output logic        m_fired,
    output logic [15:0] m_fired_tag,
    output logic [31:0] m_wait_seconds,
    output logic [1:0]  m_status,
    output logic        m_last
);
    import sdtq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TIME_BITS + TAG_BITS + HANDLE_BITS;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADD_RD  = 4'd1;
    localparam logic [3:0] ST_ADD_CMP = 4'd2;
    localparam logic [3:0] ST_REM_RD  = 4'd3;
    localparam logic [3:0] ST_REM_CMP = 4'd4;
    localparam logic [3:0] ST_CHK_RD  = 4'd5;
    localparam logic [3:0] ST_CHK_CMP = 4'd6;
    localparam logic [3:0] ST_CHK_END = 4'd7;
    localparam logic [3:0] ST_SH_RD   = 4'd8;
    localparam logic [3:0] ST_SH_WR   = 4'd9;
    localparam logic [3:0] ST_WQ_RD   = 4'd10;
    localparam logic [3:0] ST_WQ_CMP  = 4'd11;
    localparam logic [3:0] ST_RESP    = 4'd12;

    // Entry memory: {deadline, tag, handle}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [3:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [NUM_HANDLES-1:0] mask_reg, mask_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          src_reg, src_next;
    logic                   found_reg, found_next;
    logic [TIME_BITS-1:0]   dl_reg, dl_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [3:0]             hdl_reg, hdl_next;

    // Staged final result of the current request
    logic [3:0]  res_handle_reg, res_handle_next;
    logic        res_fired_reg, res_fired_next;
    logic [15:0] res_tag_reg, res_tag_next;
    logic [31:0] res_wait_reg, res_wait_next;
    logic [1:0]  res_status_reg, res_status_next;

    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_handle_reg, m_handle_next;
    logic        m_fired_reg, m_fired_next;
    logic [15:0] m_tag_reg, m_tag_next;
    logic [31:0] m_wait_reg, m_wait_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_last_reg, m_last_next;

    logic [TIME_BITS-1:0] rd_dl;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [3:0]           rd_hdl;
    logic [EW-1:0]        new_word;
    logic [TIME_BITS-1:0] cmp_b;
    sdtq_cmp_t            cmp_res;
    logic [3:0]           free_h;
    logic                 out_free;
    logic                 q_full;
    logic [CW-1:0]        dst_idx;

    assign rd_dl    = rd_data_reg[EW-1 -: TIME_BITS];
    assign rd_tag   = rd_data_reg[HANDLE_BITS +: TAG_BITS];
    assign rd_hdl   = rd_data_reg[HANDLE_BITS-1:0];
    assign new_word = {dl_reg, tag_reg, hdl_reg};
    assign out_free = !m_valid_reg || m_ready;
    assign q_full   = (count_reg == CW'(DEPTH)) || (&mask_reg);
    assign dst_idx  = src_reg - idx_reg;
    assign cmp_b    = (state_reg == ST_ADD_CMP) ? dl_reg : now_reg;

    sdtq_cmp #(
        .TIME_BITS(TIME_BITS)
    ) u_cmp (
        .a_val(rd_dl),
        .b_val(cmp_b),
        .res  (cmp_res)
    );

    // Lowest free handle
    always_comb begin
        free_h = '0;
        for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
            if (!mask_reg[i]) begin
                free_h = 4'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        src_next        = src_reg;
        found_next      = found_reg;
        dl_next         = dl_reg;
        now_next        = now_reg;
        tag_next        = tag_reg;
        hdl_next        = hdl_reg;
        res_handle_next = res_handle_reg;
        res_fired_next  = res_fired_reg;
        res_tag_next    = res_tag_reg;
        res_wait_next   = res_wait_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_handle_next   = m_handle_reg;
        m_fired_next    = m_fired_reg;
        m_tag_next      = m_tag_reg;
        m_wait_next     = m_wait_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dl_next         = TIME_BITS'(s_deadline);
                    now_next        = TIME_BITS'(s_now_seconds);
                    tag_next        = TAG_BITS'(s_tag_in);
                    hdl_next        = s_handle_in;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    res_handle_next = '0;
                    res_fired_next  = 1'b0;
                    res_tag_next    = '0;
                    res_wait_next   = '0;
                    res_status_next = STAT_OK;
                    unique case (s_req_type)
                        REQ_ADD: begin
                            if (q_full) begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_RESP;
                            end else begin
                                hdl_next   = free_h;
                                idx_next   = count_reg;
                                state_next = ST_ADD_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!mask_reg[s_handle_in]) begin
                                res_status_next = STAT_UNKNOWN;
                                state_next      = ST_RESP;
                            end else begin
                                state_next = ST_REM_RD;
                            end
                        end
                        REQ_CHECK: begin
                            state_next = ST_CHK_RD;
                        end
                        REQ_WAIT: begin
                            if (count_reg == '0) begin
                                res_wait_next = EMPTY_WAIT;
                                state_next    = ST_RESP;
                            end else begin
                                state_next = ST_WQ_RD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // Insert: walk down from the tail, moving later-or-equal entries up
            ST_ADD_RD: begin
                if (idx_reg == '0) begin
                    wr_en                = 1'b1;
                    wr_addr              = '0;
                    wr_data              = new_word;
                    res_handle_next      = hdl_reg;
                    count_next           = count_reg + CW'(1);
                    mask_next[hdl_reg]   = 1'b1;
                    state_next           = ST_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - CW'(1));
                    state_next = ST_ADD_CMP;
                end
            end

            ST_ADD_CMP: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                if (!cmp_res.a_lt_b) begin
                    wr_data    = rd_data_reg;
                    idx_next   = idx_reg - CW'(1);
                    state_next = ST_ADD_RD;
                end else begin
                    wr_data            = new_word;
                    res_handle_next    = hdl_reg;
                    count_next         = count_reg + CW'(1);
                    mask_next[hdl_reg] = 1'b1;
                    state_next         = ST_RESP;
                end
            end

            // Remove: scan forward; after the match, move each entry down one
            ST_REM_RD: begin
                if (idx_reg == count_reg) begin
                    if (found_reg) begin
                        count_next = count_reg - CW'(1);
                    end
                    mask_next[hdl_reg] = 1'b0;
                    state_next         = ST_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = ST_REM_CMP;
                end
            end

            ST_REM_CMP: begin
                if (found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - CW'(1));
                    wr_data = rd_data_reg;
                end else if (rd_hdl == hdl_reg) begin
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_REM_RD;
            end

            // Check: fire from the head; each fired tag goes out one step late
            // so the final one can carry last
            ST_CHK_RD: begin
                if ((idx_reg < count_reg) && (32'(idx_reg) < MAX_OUT)) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = ST_CHK_CMP;
                end else begin
                    state_next = ST_CHK_END;
                end
            end

            ST_CHK_CMP: begin
                if (cmp_res.a_lt_b || cmp_res.a_eq_b) begin
                    if (!res_fired_reg || out_free) begin
                        if (res_fired_reg) begin
                            m_valid_next  = 1'b1;
                            m_handle_next = '0;
                            m_fired_next  = 1'b1;
                            m_tag_next    = res_tag_reg;
                            m_wait_next   = '0;
                            m_status_next = STAT_OK;
                            m_last_next   = 1'b0;
                        end
                        res_fired_next    = 1'b1;
                        res_tag_next      = 16'(rd_tag);
                        mask_next[rd_hdl] = 1'b0;
                        idx_next          = idx_reg + CW'(1);
                        state_next        = ST_CHK_RD;
                    end
                end else begin
                    state_next = ST_CHK_END;
                end
            end

            ST_CHK_END: begin
                if (idx_reg == '0) begin
                    state_next = ST_RESP;
                end else begin
                    src_next   = idx_reg;
                    state_next = ST_SH_RD;
                end
            end

            // Close the gap left by the popped head entries
            ST_SH_RD: begin
                if (src_reg == count_reg) begin
                    count_next = count_reg - idx_reg;
                    state_next = ST_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = src_reg[AW-1:0];
                    state_next = ST_SH_WR;
                end
            end

            ST_SH_WR: begin
                wr_en      = 1'b1;
                wr_addr    = dst_idx[AW-1:0];
                wr_data    = rd_data_reg;
                src_next   = src_reg + CW'(1);
                state_next = ST_SH_RD;
            end

            ST_WQ_RD: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_WQ_CMP;
            end

            ST_WQ_CMP: begin
                res_wait_next = cmp_res.wait_sat;
                state_next    = ST_RESP;
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = res_handle_reg;
                    m_fired_next  = res_fired_reg;
                    m_tag_next    = res_tag_reg;
                    m_wait_next   = res_wait_reg;
                    m_status_next = res_status_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        src_reg        <= src_next;
        found_reg      <= found_next;
        dl_reg         <= dl_next;
        now_reg        <= now_next;
        tag_reg        <= tag_next;
        hdl_reg        <= hdl_next;
        res_handle_reg <= res_handle_next;
        res_fired_reg  <= res_fired_next;
        res_tag_reg    <= res_tag_next;
        res_wait_reg   <= res_wait_next;
        res_status_reg <= res_status_next;
        m_handle_reg   <= m_handle_next;
        m_fired_reg    <= m_fired_next;
        m_tag_reg      <= m_tag_next;
        m_wait_reg     <= m_wait_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_handle_out   = m_handle_reg;
    assign m_fired        = m_fired_reg;
    assign m_fired_tag    = m_tag_reg;
    assign m_wait_seconds = m_wait_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;

    // Fill level never passes the memory depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // Between requests every stored entry owns exactly one handle
    a_mask_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(mask_reg) == 32'(count_reg)))
        else $error("handle mask out of step with entry count");

    // Insert walk never reads below the head
    a_add_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD_CMP) |-> (idx_reg != '0))
        else $error("insert walk past head");

    // Compaction source stays at or beyond the popped count
    a_shift_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SH_WR) |-> (src_reg >= idx_reg))
        else $error("compaction source behind destination");

endmodule
